// ===== design/pdce_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the point display command encoder.
// Used by every module of the block; depends on nothing else.
package pdce_pkg;

	// Input op codes.
	localparam logic OP_POINT = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// Configuration register indexes.
	localparam logic REG_BASE_AGE = 1'b0;
	localparam logic REG_AGE_CAP  = 1'b1;

	localparam logic [19:0] BASE_AGE_RESET = 20'd50000;
	localparam logic [19:0] AGE_CAP_RESET  = 20'd1000000;
	localparam logic [20:0] AGE_RESET      = 21'd50000;

	// A point delay field tops out at 510 us, compared here in nanoseconds.
	localparam logic [30:0] DELAY_LIMIT_NS = 31'd510000;
	localparam logic [30:0] NS_PER_US      = 31'd1000;

	// floor(n / 6) = (n * SIXTH_MAGIC) >> 24, exact for n below 2^23.
	localparam logic [21:0] SIXTH_MAGIC = 22'd2796203;
	localparam int unsigned SIXTH_SHIFT = 24;

	// Inverse of 125 modulo 2^32.
	localparam logic [31:0] DIV_INV = 32'd652835029;

	localparam logic [31:0] MARKER_WORD = 32'hFF80_0000;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = 2;

	typedef logic [2:0] pdce_cnt_t;

	typedef struct packed {
		logic       has_pair;
		logic       has_point;
		logic [9:0] x;
		logic [9:0] y;
		logic [2:0] intensity;
	} pdce_cmd_t;

	typedef struct packed {
		pdce_cmd_t   cmd;
		logic [31:0] delay_us;
	} pdce_entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} pdce_qstat_t;

	typedef enum logic [1:0] {
		ST_FIRST = 2'd0,
		ST_DELAY = 2'd1,
		ST_POINT = 2'd2
	} pdce_state_t;

endpackage

// ===== design/pdce_front.sv =====
`timescale 1ns / 1ps
// Front end: input register, configuration registers, timing state and the
// per-item decision of which words follow. Depends on pdce_pkg.
module pdce_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic                  wr_index,
	input  logic [19:0]           wr_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  op,
	input  logic [9:0]            x,
	input  logic [9:0]            y,
	input  logic [2:0]            intensity,
	input  logic [63:0]           now_ns,
	input  logic                  pop,
	output logic                  vld_s2,
	output pdce_pkg::pdce_cmd_t   cmd_s2,
	output logic [63:0]           diff_s2
);

	logic        v_s1;
	logic        op_s1;
	logic [9:0]  x_s1;
	logic [9:0]  y_s1;
	logic [2:0]  int_s1;
	logic [63:0] now_s1;

	logic [19:0] base_q;
	logic [19:0] cap_q;
	logic [63:0] last_sent_q;
	logic [20:0] interval_q;
	logic [30:0] thr_q;
	logic [18:0] sixth_q;
	logic        fresh_q;
	pdce_pkg::pdce_cnt_t cnt_q;

	logic [63:0] diff;
	logic        far;
	logic        big;
	logic        due;
	logic        is_point;
	logic        mk;
	logic        upd_int;
	logic [20:0] new_int;
	logic        fire;
	logic        push;
	logic [30:0] thr_next;
	logic [42:0] sixth_prod;

	assign diff     = now_s1 - last_sent_q;
	assign far      = |diff[63:31];
	assign big      = far || (diff[30:0] >= pdce_pkg::DELAY_LIMIT_NS);
	assign due      = far || (diff[30:0] >= thr_q);
	assign is_point = (op_s1 == pdce_pkg::OP_POINT);
	assign mk       = is_point || due;
	assign upd_int  = is_point || (due && (interval_q < {1'b0, cap_q}));
	assign new_int  = is_point ? {1'b0, base_q} : (interval_q + {2'b00, sixth_q});

	// The thresholds derived from the age interval are registered from it,
	// so a decision waits while they catch up.
	assign fire     = v_s1 && fresh_q && (cnt_q < 3'(pdce_pkg::QUEUE_DEPTH));
	assign push     = fire && mk;
	assign in_ready = !v_s1 || fire;

	assign thr_next   = {10'b0, interval_q} * pdce_pkg::NS_PER_US;
	assign sixth_prod = {22'b0, interval_q} * {21'b0, pdce_pkg::SIXTH_MAGIC};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1  <= op;
			x_s1   <= x;
			y_s1   <= y;
			int_s1 <= intensity;
			now_s1 <= now_ns;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= pdce_pkg::BASE_AGE_RESET;
			cap_q  <= pdce_pkg::AGE_CAP_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				pdce_pkg::REG_BASE_AGE: base_q <= wr_data;
				pdce_pkg::REG_AGE_CAP:  cap_q  <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sent_q <= 64'd0;
			interval_q  <= pdce_pkg::AGE_RESET;
			fresh_q     <= 1'b0;
			cnt_q       <= 3'd0;
		end else begin
			if (fire && mk) begin
				last_sent_q <= now_s1;
			end
			if (fire && upd_int) begin
				interval_q <= new_int;
				fresh_q    <= 1'b0;
			end else begin
				fresh_q <= 1'b1;
			end
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end

	always_ff @(posedge clk) begin
		thr_q   <= thr_next;
		sixth_q <= sixth_prod[pdce_pkg::SIXTH_SHIFT +: 19];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			cmd_s2.has_pair  <= is_point ? big : 1'b1;
			cmd_s2.has_point <= is_point;
			cmd_s2.x         <= x_s1;
			cmd_s2.y         <= y_s1;
			cmd_s2.intensity <= int_s1;
			diff_s2          <= diff;
		end
	end

endmodule

// ===== design/pdce_div.sv =====
`timescale 1ns / 1ps
// Pipelined divide of a nanosecond difference by 1000, keeping the low 32
// bits of the quotient. Depends on pdce_pkg.
module pdce_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  vld_s2,
	input  pdce_pkg::pdce_cmd_t   cmd_s2,
	input  logic [63:0]           diff_s2,
	output logic                  vld_s6,
	output pdce_pkg::pdce_entry_t entry_s6
);

	// D / 1000 = (D/8 - (D/8 mod 125)) / 125, and the exact division by 125
	// is a multiply by its inverse modulo 2^32.
	logic [60:0] dq;
	logic [26:0] s_next;
	logic [16:0] t;
	logic [11:0] u_next;
	logic [7:0]  v;
	logic [6:0]  r;

	logic        vld_s3, vld_s4, vld_s5;
	pdce_pkg::pdce_cmd_t cmd_s3, cmd_s4, cmd_s5;
	logic [26:0] s_s3;
	logic [31:0] lo_s3, lo_s4;
	logic [11:0] u_s4;
	logic [31:0] n_s5;

	assign dq     = diff_s2[63:3];
	// 2^21 = 27 and 2^42 = 104 modulo 125.
	assign s_next = 27'(dq[20:0]) + 27'(dq[41:21]) * 27'd27 + 27'(dq[60:42]) * 27'd104;
	// 2^14 = 9 and 2^7 = 3 modulo 125.
	assign t      = 17'(s_s3[13:0]) + 17'(s_s3[26:14]) * 17'd9;
	assign u_next = 12'(t[6:0]) + 12'(t[16:7]) * 12'd3;
	assign v      = 8'(u_s4[6:0]) + 8'(u_s4[11:7]) * 8'd3;
	assign r      = (v >= 8'd125) ? 7'(v - 8'd125) : v[6:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s3            <= cmd_s2;
		s_s3              <= s_next;
		lo_s3             <= dq[31:0];
		cmd_s4            <= cmd_s3;
		u_s4              <= u_next;
		lo_s4             <= lo_s3;
		cmd_s5            <= cmd_s4;
		n_s5              <= lo_s4 - {25'b0, r};
		entry_s6.cmd      <= cmd_s5;
		entry_s6.delay_us <= n_s5 * pdce_pkg::DIV_INV;
	end

endmodule

// ===== design/pdce_queue.sv =====
`timescale 1ns / 1ps
// Four-entry queue of decided items between the front end and the word
// sequencer. Depends on pdce_pkg.
module pdce_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  pdce_pkg::pdce_entry_t push_data,
	input  logic                  pop,
	output pdce_pkg::pdce_entry_t head,
	output pdce_pkg::pdce_qstat_t stat
);

	pdce_pkg::pdce_entry_t mem [pdce_pkg::QUEUE_DEPTH];
	logic [pdce_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [pdce_pkg::QUEUE_AW-1:0] rd_ptr_q;
	pdce_pkg::pdce_cnt_t           count_q;

	assign head       = mem[rd_ptr_q];
	assign stat.empty = (count_q == 3'd0);
	assign stat.full  = (count_q == 3'(pdce_pkg::QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= 3'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + 3'(push) - 3'(pop);
		end
	end

endmodule

// ===== design/pdce_back.sv =====
`timescale 1ns / 1ps
// Word sequencer: turns each queued item into its marker, delay and point
// words and holds them in the output register. Depends on pdce_pkg.
module pdce_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pdce_pkg::pdce_entry_t head,
	input  pdce_pkg::pdce_qstat_t stat,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [31:0]           word,
	output logic                  last
);

	pdce_pkg::pdce_state_t state_q;
	pdce_pkg::pdce_state_t state_d;
	logic        load;
	logic [31:0] word_d;
	logic        last_d;
	logic [31:0] word_q;
	logic        last_q;
	logic        valid_q;
	logic [8:0]  pt_delay;
	logic [31:0] pt_word;

	// A point that followed a delay pair was drawn right after it.
	assign pt_delay = head.cmd.has_pair ? 9'd0 : head.delay_us[8:0];
	assign pt_word  = {pt_delay, head.cmd.intensity, head.cmd.y, head.cmd.x};
	assign load     = !stat.empty && (!valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		word_d  = pdce_pkg::MARKER_WORD;
		last_d  = 1'b0;
		unique case (state_q)
			pdce_pkg::ST_FIRST: begin
				if (head.cmd.has_pair) begin
					word_d = pdce_pkg::MARKER_WORD;
					last_d = 1'b0;
					if (load) begin
						state_d = pdce_pkg::ST_DELAY;
					end
				end else begin
					word_d = pt_word;
					last_d = 1'b1;
					pop    = load;
				end
			end
			pdce_pkg::ST_DELAY: begin
				word_d = head.delay_us;
				last_d = !head.cmd.has_point;
				if (load) begin
					if (head.cmd.has_point) begin
						state_d = pdce_pkg::ST_POINT;
					end else begin
						state_d = pdce_pkg::ST_FIRST;
						pop     = 1'b1;
					end
				end
			end
			pdce_pkg::ST_POINT: begin
				word_d = pt_word;
				last_d = 1'b1;
				if (load) begin
					state_d = pdce_pkg::ST_FIRST;
					pop     = 1'b1;
				end
			end
			default: begin
				state_d = pdce_pkg::ST_FIRST;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pdce_pkg::ST_FIRST;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= word_d;
			last_q <= last_d;
		end
	end

	assign out_valid = valid_q;
	assign word      = word_q;
	assign last      = last_q;

endmodule

// ===== design/point_display_command_encoder.sv =====
`timescale 1ns / 1ps
// Point display command encoder. Each item is a point or an aging tick with a nanosecond
// time; the block answers with display words, one per cycle while out_ready is high, the
// final word of an item flagged by last. A point gives one word, or three when 510 us or
// more have passed; a tick gives two words or none. The front end decides one item per
// cycle while the age interval is unchanged and the queue has room; when it changes
// (every point, every growing tick) the next decision waits while the compare thresholds
// are re-derived in a register. An accepted item passes the input and decision registers,
// the pipelined divide by 1000 and the queue before its first word reaches the output.
// Depends on pdce_pkg, pdce_front, pdce_div, pdce_queue and pdce_back.
module point_display_command_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [19:0] wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [9:0]  x,
	input  logic [9:0]  y,
	input  logic [2:0]  intensity,
	input  logic [63:0] now_ns,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] word,
	output logic        last
);

	logic                  vld_s2;
	pdce_pkg::pdce_cmd_t   cmd_s2;
	logic [63:0]           diff_s2;
	logic                  vld_s6;
	pdce_pkg::pdce_entry_t entry_s6;
	pdce_pkg::pdce_entry_t head;
	pdce_pkg::pdce_qstat_t stat;
	logic                  pop;

	pdce_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.x         (x),
		.y         (y),
		.intensity (intensity),
		.now_ns    (now_ns),
		.pop       (pop),
		.vld_s2    (vld_s2),
		.cmd_s2    (cmd_s2),
		.diff_s2   (diff_s2)
	);

	pdce_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_s2   (vld_s2),
		.cmd_s2   (cmd_s2),
		.diff_s2  (diff_s2),
		.vld_s6   (vld_s6),
		.entry_s6 (entry_s6)
	);

	pdce_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (vld_s6),
		.push_data (entry_s6),
		.pop       (pop),
		.head      (head),
		.stat      (stat)
	);

	pdce_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.stat      (stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.word      (word),
		.last      (last)
	);

	// The front end's credit count must keep the queue from overflowing.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 |-> !stat.full)
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("queue pop while empty");

	// Words of one item leave without a gap once the first is taken.
	a_item_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last) |=> out_valid)
		else $error("gap inside an item's words");

	// Every item entering the queue produces at least one word.
	a_entry_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 |-> (entry_s6.cmd.has_pair || entry_s6.cmd.has_point))
		else $error("queued item without words");

endmodule

// ===== sim/tb_point_display_command_encoder.sv =====
`timescale 1ns / 1ps
// Testbench for point_display_command_encoder: random and directed points and ticks under
// random stalls on both channels, every output word checked against an in-bench predictor.
// Depends on pdce_pkg and the design sources of the block.
module tb_point_display_command_encoder;

	localparam int unsigned CYCLE_LIMIT  = 500_000;
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam int unsigned PHASE_ITEMS  = 69;
	localparam int unsigned HOLD_CYCLES  = 300;

	typedef struct packed {
		logic [31:0] word;
		logic        last;
	} cmd_word_t;

	// Predicts the command words of each accepted item and checks them in order.
	class display_word_board;
		cmd_word_t   expected_words[$];
		logic [63:0] last_sent_ns;
		logic [20:0] age_us;
		logic [19:0] base_us;
		logic [19:0] cap_us;
		int unsigned errors;
		int unsigned points;
		int unsigned ticks;
		int unsigned aging_ticks;
		int unsigned delay_pairs;
		int unsigned checked;

		function new();
			last_sent_ns = '0;
			age_us       = pdce_pkg::AGE_RESET;
			base_us      = pdce_pkg::BASE_AGE_RESET;
			cap_us       = pdce_pkg::AGE_CAP_RESET;
		endfunction

		function void set_reg(logic index, logic [19:0] value);
			if (index == pdce_pkg::REG_BASE_AGE)
				base_us = value;
			else
				cap_us = value;
		endfunction

		function void predict_words(logic op_i, logic [9:0] x_i, logic [9:0] y_i,
			logic [2:0] int_i, logic [63:0] now);
			logic [63:0] gap_us;
			logic [8:0]  delay_field;
			logic [31:0] words[$];
			cmd_word_t   entry;
			gap_us = (now - last_sent_ns) / 64'd1000;
			if (op_i == pdce_pkg::OP_POINT) begin
				points++;
				if (gap_us >= 64'd510) begin
					words.push_back(pdce_pkg::MARKER_WORD);
					words.push_back(gap_us[31:0]);
					last_sent_ns = now;
					delay_pairs++;
				end
				age_us = {1'b0, base_us};
				gap_us = (now - last_sent_ns) / 64'd1000;
				delay_field = (gap_us > 64'd510) ? 9'd510 : gap_us[8:0];
				last_sent_ns = now;
				words.push_back({delay_field, int_i, y_i, x_i});
			end else begin
				ticks++;
				if (gap_us >= {43'd0, age_us}) begin
					words.push_back(pdce_pkg::MARKER_WORD);
					words.push_back(gap_us[31:0]);
					last_sent_ns = now;
					aging_ticks++;
					delay_pairs++;
					if (age_us < {1'b0, cap_us})
						age_us = age_us + age_us / 21'd6;
				end
			end
			foreach (words[k]) begin
				entry.word = words[k];
				entry.last = (k == words.size() - 1);
				expected_words.push_back(entry);
			end
		endfunction

		function void check_word(logic [31:0] w, logic l);
			cmd_word_t want;
			if (expected_words.size() == 0) begin
				$error("unexpected word %h with last %b", w, l);
				errors++;
				return;
			end
			want = expected_words.pop_front();
			checked++;
			if (w !== want.word) begin
				$error("word: expected %h, got %h", want.word, w);
				errors++;
			end
			if (l !== want.last) begin
				$error("last: expected %b, got %b", want.last, l);
				errors++;
			end
		endfunction

		function int pending();
			return expected_words.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        wr_en;
	logic        wr_index;
	logic [19:0] wr_data;
	logic        in_valid;
	logic        in_ready;
	logic        op;
	logic [9:0]  x;
	logic [9:0]  y;
	logic [2:0]  intensity;
	logic [63:0] now_ns;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] word;
	logic        last;

	display_word_board sb = new();
	logic [63:0] stamp_ns;
	bit          steady;
	bit          long_hold;
	int unsigned cycle_count;
	int unsigned settings_run;

	point_display_command_encoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.x         (x),
		.y         (y),
		.intensity (intensity),
		.now_ns    (now_ns),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.word      (word),
		.last      (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_word(word, last);
	end

	// Mostly short gaps, a few long ones; none at all while steady is set.
	function automatic int unsigned idle_gap();
		int unsigned r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Result side: random stalls, and one long hold-off on request so that the block backs up.
	initial begin
		int unsigned gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				long_hold = 1'b0;
			end else begin
				@(negedge clk);
				out_ready <= 1'b1;
				gap = idle_gap();
				if (gap > 0) begin
					@(negedge clk);
					out_ready <= 1'b0;
					repeat (gap - 1) @(negedge clk);
				end
			end
		end
	end

	task automatic send_item(logic o, logic [9:0] xx, logic [9:0] yy, logic [2:0] ii,
		logic [63:0] t);
		int unsigned gap;
		@(negedge clk);
		in_valid  <= 1'b1;
		op        <= o;
		x         <= xx;
		y         <= yy;
		intensity <= ii;
		now_ns    <= t;
		stamp_ns = t;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.predict_words(o, xx, yy, ii, t);
		gap = idle_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		// A tick may still be in flight without producing any word.
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic index, logic [19:0] value);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= index;
		wr_data  <= value;
		@(negedge clk);
		wr_en <= 1'b0;
		sb.set_reg(index, value);
	endtask

	// Next timestamp: often near the point and aging thresholds, else random steps and some jumps anywhere.
	function automatic logic [63:0] next_time(logic [63:0] t);
		int unsigned r;
		logic [63:0] age_ns;
		logic [63:0] c;
		age_ns = 64'(sb.age_us) * 64'd1000;
		r = $urandom_range(0, 99);
		if (r < 30)
			return t + $urandom_range(0, 509_999);
		if (r < 45)
			c = sb.last_sent_ns + 64'd509_000 + $urandom_range(0, 2000);
		else if (r < 70)
			c = (age_ns < 64'd1000) ? sb.last_sent_ns + $urandom_range(0, 2000)
				: sb.last_sent_ns + age_ns - 64'd1000 + $urandom_range(0, 2000);
		else if (r < 88)
			return t + $urandom_range(0, 32'(age_ns * 3) + 1_000_000);
		else if (r < 94)
			return {$urandom, $urandom};
		else if (r < 97)
			return t - $urandom_range(1, 2_000_000);
		else
			return t;
		return (c < t) ? t : c;
	endfunction

	task automatic random_items(int unsigned count);
		logic o;
		repeat (count) begin
			o = ($urandom_range(0, 99) < 55) ? pdce_pkg::OP_POINT : pdce_pkg::OP_TICK;
			send_item(o, 10'($urandom), 10'($urandom), 3'($urandom), next_time(stamp_ns));
		end
	endtask

	task automatic directed_items();
		logic [63:0] t;
		send_item(pdce_pkg::OP_POINT, 10'd0, 10'd0, 3'd0, 64'd0);
		t = 64'd509_999;
		send_item(pdce_pkg::OP_POINT, 10'd1023, 10'd1023, 3'd7, t);
		// Exactly 510 us after the last word brings the delay pair.
		t = t + 64'd510_000;
		send_item(pdce_pkg::OP_POINT, 10'd512, 10'd341, 3'd5, t);
		t = t + 64'd511_000;
		send_item(pdce_pkg::OP_POINT, 10'd1, 10'd2, 3'd3, t);
		t = t + 64'd300;
		send_item(pdce_pkg::OP_POINT, 10'd5, 10'd5, 3'd2, t);
		// Ticks just below and just at the age interval, then after it has grown.
		t = t + 64'd49_999_999;
		send_item(pdce_pkg::OP_TICK, 10'd1023, 10'd0, 3'd7, t);
		t = t + 64'd1;
		send_item(pdce_pkg::OP_TICK, 10'd0, 10'd1023, 3'd0, t);
		t = t + 64'd58_332_999;
		send_item(pdce_pkg::OP_TICK, 10'd341, 10'd682, 3'd4, t);
		t = t + 64'd1000;
		send_item(pdce_pkg::OP_TICK, 10'd682, 10'd341, 3'd3, t);
		t = t + 64'd1;
		send_item(pdce_pkg::OP_TICK, 10'd3, 10'd9, 3'd1, t);
		t = t + 64'd1_000_000;
		send_item(pdce_pkg::OP_POINT, 10'd100, 10'd200, 3'd6, t);
		// Time running backwards wraps into a huge delay.
		t = t - 64'd1;
		send_item(pdce_pkg::OP_POINT, 10'd7, 10'd8, 3'd1, t);
		// A delay wider than 32 bits of microseconds.
		t = t + 64'd5_000_000_000_000;
		send_item(pdce_pkg::OP_POINT, 10'd1000, 10'd24, 3'd5, t);
		send_item(pdce_pkg::OP_POINT, 10'd1023, 10'd0, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(pdce_pkg::OP_TICK, 10'd0, 10'd0, 3'd0, 64'd0);
		send_item(pdce_pkg::OP_TICK, 10'd1023, 10'd1023, 3'd7, 64'hFFFF_FFFF_FFFF_0000);
		send_item(pdce_pkg::OP_POINT, 10'd0, 10'd1023, 3'd0, 64'hFFFF_FFFF_FFFF_0000);
	endtask

	task automatic run_setting(logic [19:0] base, logic [19:0] cap, bit no_gaps, bit hold);
		write_reg(pdce_pkg::REG_BASE_AGE, base);
		write_reg(pdce_pkg::REG_AGE_CAP, cap);
		steady = no_gaps;
		long_hold = hold;
		settings_run++;
		random_items(PHASE_ITEMS);
		drain();
	endtask

	initial begin
		arst_n    = 1'b0;
		wr_en     = 1'b0;
		wr_index  = pdce_pkg::REG_BASE_AGE;
		wr_data   = '0;
		in_valid  = 1'b0;
		op        = pdce_pkg::OP_POINT;
		x         = '0;
		y         = '0;
		intensity = '0;
		now_ns    = '0;
		stamp_ns  = '0;
		steady    = 1'b0;
		long_hold = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		directed_items();
		drain();
		settings_run = 1;
		steady = 1'b1;
		random_items(PHASE_ITEMS);
		drain();

		run_setting(20'd1, 20'hFFFFF, 1'b0, 1'b1);
		run_setting(20'hFFFFF, 20'd1, 1'b1, 1'b0);
		run_setting(20'd0, 20'd0, 1'b0, 1'b0);
		run_setting(20'd200, 20'd3000, 1'b0, 1'b0);
		run_setting(20'($urandom_range(0, 20'hFFFFF)), 20'($urandom_range(0, 20'hFFFFF)),
			1'b0, 1'b0);

		$display("Run covered %0d points and %0d ticks (%0d of them aging), %0d delay pairs,",
			sb.points, sb.ticks, sb.aging_ticks, sb.delay_pairs);
		$display("%0d words checked over %0d register settings.", sb.checked, settings_run);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== files.f =====
design/pdce_pkg.sv
design/pdce_front.sv
design/pdce_div.sv
design/pdce_queue.sv
design/pdce_back.sv
design/point_display_command_encoder.sv
sim/tb_point_display_command_encoder.sv
